// ===== rtl/crre_pkg.sv =====
// shared types and constants for the catmull-rom ring evaluator
package crre_pkg;

	localparam int COORD_W = 24;
	localparam int SEG_W   = 10;
	localparam int FRAC_W  = 16;

	// operation codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_EVAL   = 2'd2
	} op_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic        [1:0]         operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic        [SEG_W-1:0]   segment_index;
		logic        [FRAC_W-1:0]  param_frac;
	} cmd_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic        [1:0]         status;
	} result_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// control that rides along with an item behind the memory read
	typedef struct packed {
		logic        valid;
		logic        eval_ok;
		logic [1:0]  status;
	} ctl_t;

endpackage

// ===== rtl/catmull_rom_ring_evaluator_core.sv =====
// top level of the closed catmull-rom ring evaluator
// Usage: a command word on cmd is taken at a rising edge with start high and
// busy low. busy is always low, so one word may be taken every cycle.
// A clear empties the ring, an append stores a point (status full when the
// ring holds MAX_POINTS), an evaluate blends the four ring neighbours of the
// reduced segment at the fraction (status empty on an empty ring).
// Every command word yields exactly one result word on result, marked by done
// for one cycle, in command order. Throughput is one word per cycle: the
// index reduction runs in two stages, the point memory has one bank per
// neighbour so all four reads issue in the same cycle, and the blend runs in
// seven multiply and add stages per coordinate.
// Appends are written to memory at the read stage, in order with evaluates.
// Reset empties the ring and drops every word in flight; stored points are
// not cleared and are read only after being appended.
// The receiver cannot stall: results are not held.
module catmull_rom_ring_evaluator_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  crre_pkg::cmd_word_t     cmd,
	output logic                    done,
	output crre_pkg::result_word_t  result
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int DLY = 7;

	logic accept;
	logic [CW-1:0] count_q;

	logic v_s1, v_s2, v_s3;
	logic eval_s1, eval_s2, eval_s3;
	logic wr_s1, wr_s2, wr_s3;
	logic [1:0] status_s1, status_s2, status_s3;
	logic [CW-1:0] count_s1;
	logic [AW-1:0] wa_s1, wa_s2, wa_s3;
	crre_pkg::point_t wd_s1, wd_s2, wd_s3;
	logic [crre_pkg::SEG_W-1:0] seg_s1;
	logic [crre_pkg::FRAC_W-1:0] t_s1, t_s2, t_s3, t_s4;
	crre_pkg::ctl_t ctl_q [DLY+1];

	logic [CW-1:0] seg_m, n_m;
	logic [CW-1:0] ic_w;
	logic [CW:0] id_w;
	logic [3:0][AW-1:0] rd_addr;
	crre_pkg::point_t rd_data [4];
	logic signed [crre_pkg::COORD_W-1:0] px, py, pz;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// point count and command intake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept) begin
				if (cmd.operation == crre_pkg::OP_CLEAR) begin
					count_q <= '0;
				end else if (cmd.operation == crre_pkg::OP_APPEND
					&& count_q != CW'(MAX_POINTS)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// payload of the first three stages
	always_ff @(posedge clk) begin
		eval_s1   <= 1'b0;
		wr_s1     <= 1'b0;
		status_s1 <= crre_pkg::ST_OK;
		if (cmd.operation == crre_pkg::OP_APPEND) begin
			if (count_q == CW'(MAX_POINTS)) status_s1 <= crre_pkg::ST_FULL;
			else wr_s1 <= accept;
		end else if (cmd.operation == crre_pkg::OP_EVAL) begin
			if (count_q == '0) status_s1 <= crre_pkg::ST_EMPTY;
			else eval_s1 <= 1'b1;
		end
		count_s1 <= count_q;
		wa_s1    <= count_q[AW-1:0];
		wd_s1    <= '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
		seg_s1   <= cmd.segment_index;
		t_s1     <= cmd.param_frac;

		eval_s2   <= eval_s1;
		wr_s2     <= wr_s1 && v_s1;
		status_s2 <= status_s1;
		wa_s2     <= wa_s1;
		wd_s2     <= wd_s1;
		t_s2      <= t_s1;

		eval_s3   <= eval_s2;
		wr_s3     <= wr_s2 && v_s2;
		status_s3 <= status_s2;
		wa_s3     <= wa_s2;
		wd_s3     <= wd_s2;
		t_s3      <= t_s2;
		t_s4      <= t_s3;
	end

	crre_seg_mod #(.CW(CW)) u_seg_mod (
		.clk     (clk),
		.seg     (seg_s1),
		.n       (count_s1),
		.seg_mod (seg_m),
		.n_out   (n_m)
	);

	// neighbour addresses with wrap
	always_comb begin
		ic_w = seg_m + 1'b1;
		if (ic_w == n_m) ic_w = '0;
		id_w = (CW+1)'(seg_m) + 2'd2;
		if (n_m == CW'(1)) id_w = '0;
		else if (id_w >= (CW+1)'(n_m)) id_w = id_w - (CW+1)'(n_m);
		rd_addr[0] = (seg_m == '0) ? AW'(n_m - 1'b1) : AW'(seg_m - 1'b1);
		rd_addr[1] = seg_m[AW-1:0];
		rd_addr[2] = ic_w[AW-1:0];
		rd_addr[3] = id_w[AW-1:0];
	end

	crre_point_ram #(.DEPTH(MAX_POINTS), .AW(AW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_s3 && v_s3),
		.wr_addr (wa_s3),
		.wr_data (wd_s3),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	crre_blend_lane u_lane_x (
		.clk (clk), .a (rd_data[0].x), .b (rd_data[1].x),
		.c (rd_data[2].x), .d (rd_data[3].x), .t (t_s4), .pos (px)
	);
	crre_blend_lane u_lane_y (
		.clk (clk), .a (rd_data[0].y), .b (rd_data[1].y),
		.c (rd_data[2].y), .d (rd_data[3].y), .t (t_s4), .pos (py)
	);
	crre_blend_lane u_lane_z (
		.clk (clk), .a (rd_data[0].z), .b (rd_data[1].z),
		.c (rd_data[2].z), .d (rd_data[3].z), .t (t_s4), .pos (pz)
	);

	// control delay alongside the blend lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DLY; i++) ctl_q[i] <= '0;
		end else begin
			ctl_q[0] <= '{valid: v_s3, eval_ok: eval_s3, status: status_s3};
			for (int i = 1; i <= DLY; i++) ctl_q[i] <= ctl_q[i-1];
		end
	end

	// result word
	always_comb begin
		done          = ctl_q[DLY].valid;
		result.status = ctl_q[DLY].status;
		result.pos_x  = ctl_q[DLY].eval_ok ? px : '0;
		result.pos_y  = ctl_q[DLY].eval_ok ? py : '0;
		result.pos_z  = ctl_q[DLY].eval_ok ? pz : '0;
	end

endmodule

// ===== rtl/crre_seg_mod.sv =====
// two-stage restoring reduction of the segment index modulo the point count
module crre_seg_mod #(
	parameter int CW = 7
) (
	input  logic                      clk,
	input  logic [crre_pkg::SEG_W-1:0] seg,
	input  logic [CW-1:0]             n,
	output logic [CW-1:0]             seg_mod,
	output logic [CW-1:0]             n_out
);

	localparam int RW   = crre_pkg::SEG_W + CW;
	localparam int HALF = crre_pkg::SEG_W / 2;

	logic [RW-1:0] r_s2, r_s3;
	logic [CW-1:0] n_s2, n_s3;
	logic [RW-1:0] hi_r, lo_r;

	// upper shift positions
	always_comb begin
		hi_r = RW'(seg);
		for (int k = crre_pkg::SEG_W - 1; k >= HALF; k--) begin
			if (hi_r >= (RW'(n) << k)) hi_r = hi_r - (RW'(n) << k);
		end
	end

	// lower shift positions
	always_comb begin
		lo_r = r_s2;
		for (int k = HALF - 1; k >= 0; k--) begin
			if (lo_r >= (RW'(n_s2) << k)) lo_r = lo_r - (RW'(n_s2) << k);
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= hi_r;
		n_s2 <= n;
		r_s3 <= lo_r;
		n_s3 <= n_s2;
	end

	assign seg_mod = r_s3[CW-1:0];
	assign n_out   = n_s3;

endmodule

// ===== rtl/crre_point_ram.sv =====
// control point store, one bank per neighbour read port
module crre_point_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  crre_pkg::point_t    wr_data,
	input  logic [3:0][AW-1:0]  rd_addr,
	output crre_pkg::point_t    rd_data [4]
);

	for (genvar g = 0; g < 4; g++) begin : g_bank
		crre_pkg::point_t mem [DEPTH];

		// every bank takes every write, each reads one neighbour
		always_ff @(posedge clk) begin
			if (wr_en) mem[wr_addr] <= wr_data;
			rd_data[g] <= mem[rd_addr[g]];
		end
	end

endmodule

// ===== rtl/crre_blend_lane.sv =====
// pipelined cubic blend and saturation for one coordinate
module crre_blend_lane (
	input  logic                               clk,
	input  logic signed [crre_pkg::COORD_W-1:0] a,
	input  logic signed [crre_pkg::COORD_W-1:0] b,
	input  logic signed [crre_pkg::COORD_W-1:0] c,
	input  logic signed [crre_pkg::COORD_W-1:0] d,
	input  logic        [crre_pkg::FRAC_W-1:0]  t,
	output logic signed [crre_pkg::COORD_W-1:0] pos
);

	localparam int FW = crre_pkg::FRAC_W;
	localparam int CWD = crre_pkg::COORD_W;

	logic signed [27:0] k3_s5, k2_s5, k1_s5;
	logic signed [27:0] k2_s6, k1_s6, k1_s7, k1_s8;
	logic signed [CWD-1:0] b_s5, b_s6, b_s7, b_s8, b_s9, b_s10;
	logic [FW-1:0] t_s5, t_s6, t_s7, t_s8, t_s9;
	logic signed [44:0] m1_s6;
	logic signed [47:0] h1_s7;
	logic signed [48:0] phi_s8;
	logic [32:0] plo_s8;
	logic signed [47:0] r2_s9;
	logic signed [48:0] qhi_s10;
	logic [32:0] qlo_s10;
	logic signed [CWD-1:0] pos_s11;

	logic signed [27:0] ax, bx, cx, dx;
	logic signed [63:0] h2, h3, r3;
	logic signed [CWD-1:0] sat;

	// control points sign-extended to the coefficient width
	always_comb begin
		ax = 28'(a);
		bx = 28'(b);
		cx = 28'(c);
		dx = 28'(d);
	end

	// rounded second stage and final sum with saturation
	always_comb begin
		h2 = (64'(phi_s8) <<< FW) + $signed({31'b0, plo_s8})
			+ (64'(k1_s8) <<< 32) + 64'sd32768;
		h3 = (64'(qhi_s10) <<< FW) + $signed({31'b0, qlo_s10})
			+ (64'(b_s10) <<< 33) + 64'sd4294967296;
		r3 = h3 >>> 33;
		if (r3 > 64'sd8388607) sat = {1'b0, {(CWD-1){1'b1}}};
		else if (r3 < -64'sd8388608) sat = {1'b1, {(CWD-1){1'b0}}};
		else sat = r3[CWD-1:0];
	end

	always_ff @(posedge clk) begin
		k3_s5 <= -ax + 28'sd3 * bx - 28'sd3 * cx + dx;
		k2_s5 <= 28'sd2 * ax - 28'sd5 * bx + 28'sd4 * cx - dx;
		k1_s5 <= cx - ax;
		b_s5  <= b;
		t_s5  <= t;

		m1_s6 <= 45'(k3_s5) * 45'($signed({1'b0, t_s5}));
		k2_s6 <= k2_s5;
		k1_s6 <= k1_s5;
		b_s6  <= b_s5;
		t_s6  <= t_s5;

		h1_s7 <= 48'(m1_s6) + (48'(k2_s6) <<< FW);
		k1_s7 <= k1_s6;
		b_s7  <= b_s6;
		t_s7  <= t_s6;

		// split the wide product into signed high and unsigned low halves
		phi_s8 <= 49'($signed(h1_s7[47:FW])) * 49'($signed({1'b0, t_s7}));
		plo_s8 <= 33'(h1_s7[FW-1:0]) * 33'(t_s7);
		k1_s8  <= k1_s7;
		b_s8   <= b_s7;
		t_s8   <= t_s7;

		r2_s9 <= 48'(h2 >>> FW);
		b_s9  <= b_s8;
		t_s9  <= t_s8;

		qhi_s10 <= 49'($signed(r2_s9[47:FW])) * 49'($signed({1'b0, t_s9}));
		qlo_s10 <= 33'(r2_s9[FW-1:0]) * 33'(t_s9);
		b_s10   <= b_s9;

		pos_s11 <= sat;
	end

	assign pos = pos_s11;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the catmull-rom ring evaluator core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = 64;
	localparam int RANDOM_CMDS = 970;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;
	localparam int CMD_W       = $bits(crre_pkg::cmd_word_t);

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	crre_pkg::cmd_word_t    cmd;
	logic                   done;
	crre_pkg::result_word_t result;

	catmull_rom_ring_evaluator_core #(.MAX_POINTS(RING_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the ring
	logic signed [crre_pkg::COORD_W-1:0] ring_x [RING_DEPTH];
	logic signed [crre_pkg::COORD_W-1:0] ring_y [RING_DEPTH];
	logic signed [crre_pkg::COORD_W-1:0] ring_z [RING_DEPTH];
	int unsigned ring_count;

	crre_pkg::result_word_t pending_results[$];
	int  errors;
	int  idle_cycles;
	bit  timed_out;

	// rounding shift toward minus infinity
	function automatic longint floor_div(longint v, int n);
		return v >>> n;
	endfunction

	// one coordinate of the cubic blend, saturated
	function automatic logic signed [crre_pkg::COORD_W-1:0] blend_coord(longint a,
			longint b, longint c, longint d, longint t);
		longint k3, k2, k1, h1, h2, r2, h3, r;
		k3 = -a + 3*b - 3*c + d;
		k2 = 2*a - 5*b + 4*c - d;
		k1 = c - a;
		h1 = k3*t + k2*65536;
		h2 = h1*t + k1*64'sd4294967296;
		r2 = floor_div(h2 + 32768, 16);
		h3 = r2*t + 2*b*64'sd4294967296;
		r  = floor_div(h3 + 64'sd4294967296, 33);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[crre_pkg::COORD_W-1:0];
	endfunction

	// predict the result word of one command and update the ring
	function automatic crre_pkg::result_word_t predict_curve(crre_pkg::cmd_word_t w);
		crre_pkg::result_word_t rw;
		int unsigned s, ia, ib, ic, id;
		longint t;
		rw = '0;
		rw.status = crre_pkg::ST_OK;
		case (w.operation)
			crre_pkg::OP_CLEAR: begin
				ring_count = 0;
			end
			crre_pkg::OP_APPEND: begin
				if (ring_count >= RING_DEPTH) rw.status = crre_pkg::ST_FULL;
				else begin
					ring_x[ring_count] = w.coord_x;
					ring_y[ring_count] = w.coord_y;
					ring_z[ring_count] = w.coord_z;
					ring_count++;
				end
			end
			crre_pkg::OP_EVAL: begin
				if (ring_count == 0) rw.status = crre_pkg::ST_EMPTY;
				else begin
					s  = w.segment_index % ring_count;
					ia = (s + ring_count - 1) % ring_count;
					ib = s;
					ic = (s + 1) % ring_count;
					id = (s + 2) % ring_count;
					t  = w.param_frac;
					rw.pos_x = blend_coord(ring_x[ia], ring_x[ib], ring_x[ic],
						ring_x[id], t);
					rw.pos_y = blend_coord(ring_y[ia], ring_y[ib], ring_y[ic],
						ring_y[id], t);
					rw.pos_z = blend_coord(ring_z[ia], ring_z[ib], ring_z[ic],
						ring_z[id], t);
				end
			end
			default: ;
		endcase
		return rw;
	endfunction

	// directed table: command plus optional typed-in expectation
	typedef struct {
		crre_pkg::cmd_word_t    w;
		bit                     typed;
		crre_pkg::result_word_t want;
	} curve_row_t;
	curve_row_t curve_rows[$];

	function automatic crre_pkg::cmd_word_t mk_cmd(logic [1:0] op, int x, int y, int z,
			int seg, int fr);
		crre_pkg::cmd_word_t w;
		w.operation = op;
		w.coord_x = crre_pkg::COORD_W'(x);
		w.coord_y = crre_pkg::COORD_W'(y);
		w.coord_z = crre_pkg::COORD_W'(z);
		w.segment_index = crre_pkg::SEG_W'(seg);
		w.param_frac = crre_pkg::FRAC_W'(fr);
		return w;
	endfunction

	function automatic void add_row(crre_pkg::cmd_word_t w, bit typed, int st);
		curve_row_t r;
		r.w = w; r.typed = typed; r.want = '0; r.want.status = 2'(st);
		curve_rows.push_back(r);
	endfunction

	// random command biased toward building rings and evaluating them
	function automatic crre_pkg::cmd_word_t rand_cmd();
		crre_pkg::cmd_word_t w;
		int sel;
		w = CMD_W'({$urandom, $urandom, $urandom, $urandom});
		sel = $urandom_range(0, 99);
		if (sel < 3) w.operation = crre_pkg::OP_CLEAR;
		else if (sel < 35) w.operation = crre_pkg::OP_APPEND;
		else if (sel < 97) w.operation = crre_pkg::OP_EVAL;
		else w.operation = 2'd3;
		if ($urandom_range(0, 3) == 0) begin
			w.coord_x = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			w.coord_y = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			w.coord_z = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
		end
		return w;
	endfunction

	// result checker
	always @(posedge clk) begin
		crre_pkg::result_word_t exp_w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, result);
				errors++;
			end else begin
				exp_w = pending_results.pop_front();
				if (result.pos_x !== exp_w.pos_x) begin
					$display("%0t: pos_x expected %h actual %h", $time, exp_w.pos_x,
						result.pos_x);
					errors++;
				end
				if (result.pos_y !== exp_w.pos_y) begin
					$display("%0t: pos_y expected %h actual %h", $time, exp_w.pos_y,
						result.pos_y);
					errors++;
				end
				if (result.pos_z !== exp_w.pos_z) begin
					$display("%0t: pos_z expected %h actual %h", $time, exp_w.pos_z,
						result.pos_z);
					errors++;
				end
				if (result.status !== exp_w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_w.status,
						result.status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with nothing accepted and no result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
	end

	// hold start and cmd for one word, return after acceptance
	task automatic send_word(crre_pkg::cmd_word_t w, bit typed,
			crre_pkg::result_word_t want);
		crre_pkg::result_word_t pred;
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy && !timed_out);
		pred = predict_curve(w);
		if (typed && pred !== want)
			$display("%0t: table row disagrees with prediction", $time);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int burst;
		errors = 0; idle_cycles = 0; timed_out = 1'b0; ring_count = 0;
		start = 1'b0; cmd = '0; arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty ring, extremes, few points, clear, odd opcode
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 0, 0), 1, crre_pkg::ST_EMPTY);
		add_row(mk_cmd(2'd3, 0, 0, 0, 1023, 65535), 1, crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_APPEND, 8388607, -8388608, 256, 0, 0), 1,
			crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 1023, 0), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 5, 65535), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_APPEND, -8388608, 8388607, -1, 0, 0), 1,
			crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 1, 32768), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_APPEND, 8388607, 8388607, 0, 0, 0), 1,
			crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 2, 65535), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_APPEND, -8388608, -8388608, 100, 0, 0), 1,
			crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 1023, 1), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 0, 65535), 0, 0);
		add_row(mk_cmd(crre_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 1, crre_pkg::ST_OK);
		add_row(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 3, 3), 1, crre_pkg::ST_EMPTY);
		foreach (curve_rows[i])
			send_word(curve_rows[i].w, curve_rows[i].typed, curve_rows[i].want);

		// fill the ring past full
		for (int i = 0; i < RING_DEPTH + 2; i++)
			send_word(rand_cmd() & ~{2'b11, 98'd0} | {crre_pkg::OP_APPEND, 98'd0}, 0, '0);
		send_word(mk_cmd(crre_pkg::OP_EVAL, 0, 0, 0, 1023, 40000), 0, '0);

		// random part in bursts; one pause until every word is back
		for (int n = 0; n < RANDOM_CMDS && !timed_out; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_CMDS; k++, n++)
				send_word(rand_cmd(), 0, '0);
			if (n > RANDOM_CMDS / 2 && n - burst <= RANDOM_CMDS / 2) begin
				start <= 1'b0;
				while (pending_results.size() != 0 && !timed_out) @(posedge clk);
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
		end
		start <= 1'b0;

		while (pending_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (timed_out) begin
			$display("testbench NOT OK");
		end else if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
